// ----- rtl/sst_pkg.sv -----
// Shared constants and field layout for the sorted key table.
`default_nettype none
package sst_pkg;

    // Table depth and derived widths
    localparam int CAPACITY = 128;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Field widths
    localparam int KEY_W    = 32;
    localparam int OP_W     = 2;
    localparam int FLD_W    = 8;
    localparam int STAT_W   = 2;
    localparam int OUT_W    = 32;

    // Operation codes
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STAT_W-1:0] ST_PRESENT = 2'd1;
    localparam logic [STAT_W-1:0] ST_ABSENT  = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

    // Result word bit positions, lowest field first
    localparam int FOUND_LSB   = 0;
    localparam int POS_LSB     = 1;
    localparam int BELOW_LSB   = 9;
    localparam int ENTRIES_LSB = 17;
    localparam int STATUS_LSB  = 25;

endpackage
`default_nettype wire

// ----- rtl/sorted_set_table.sv -----
// Sorted table of distinct signed keys with binary search, insert and delete.
//
//  channel   dir  tdata                          tuser
//  s_axis    in   key[31:0]                      operation[1:0]
//  m_axis    out  found, position, below_index,  -
//                 entries_after, status
//
// One word at a time. Each search probe is a memory read, then a compare;
// there are at most log2(CAPACITY)+1 probes, plus a closing probe state on a
// miss and a decide state. An insert that moves entries does a first read,
// one move per cycle, then a key write; a delete moves entries down likewise,
// all through the single table RAM. A final state hands the result to the
// output register once it is free. Worst case is an insert at the front
// of 127 keys. Reset clears the count and control; the table contents are
// not cleared. s_axis_tready is high only while idle; a held result may
// wait in the output register while the next word is taken and searched.
`default_nettype none
module sorted_set_table (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [sst_pkg::KEY_W-1:0]  s_axis_tdata,  // key[31:0]
    input  wire logic [sst_pkg::OP_W-1:0]   s_axis_tuser,  // operation[1:0]
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    // found[0], position[8:1], below_index[16:9], entries_after[24:17],
    // status[26:25], zero[31:27]
    output logic [sst_pkg::OUT_W-1:0]       m_axis_tdata
);
    import sst_pkg::*;

    // Sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_PROBE    = 4'd1;
    localparam logic [3:0] S_CMP      = 4'd2;
    localparam logic [3:0] S_DECIDE   = 4'd3;
    localparam logic [3:0] S_UP_FIRST = 4'd4;
    localparam logic [3:0] S_UP       = 4'd5;
    localparam logic [3:0] S_DN       = 4'd6;
    localparam logic [3:0] S_FIN      = 4'd7;
    localparam logic [3:0] S_PUT      = 4'd8;

    logic [KEY_W-1:0] mem [CAPACITY];

    logic [3:0]         r_state, n_state;
    logic [OP_W-1:0]    r_op, n_op;
    logic [KEY_W-1:0]   r_key, n_key;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_lo, n_lo;
    logic [CNT_W-1:0]   r_hx, n_hx;
    logic [IDX_W-1:0]   r_mid, n_mid;
    logic [IDX_W-1:0]   r_src, n_src;
    logic [CNT_W-1:0]   r_pos, n_pos;
    logic               r_hit, n_hit;
    logic [STAT_W-1:0]  r_status, n_status;
    logic               r_out_valid, n_out_valid;
    logic [OUT_W-1:0]   r_out_data, n_out_data;
    logic [KEY_W-1:0]   r_rdata;

    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [KEY_W-1:0]   wr_data;

    logic [CNT_W:0]     mid_sum;
    logic               key_less;
    logic [FLD_W-1:0]   pos8;
    logic [FLD_W-1:0]   below8;

    // Probe midpoint and signed compare
    assign mid_sum  = {1'b0, r_lo} + {1'b0, r_hx} - (CNT_W+1)'(1);
    assign key_less = $signed(r_key) < $signed(r_rdata);
    assign pos8     = FLD_W'(r_pos);
    assign below8   = r_hit ? pos8 : pos8 - FLD_W'(1);

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_key       = r_key;
        n_count     = r_count;
        n_lo        = r_lo;
        n_hx        = r_hx;
        n_mid       = r_mid;
        n_src       = r_src;
        n_pos       = r_pos;
        n_hit       = r_hit;
        n_status    = r_status;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        rd_en       = 1'b0;
        rd_addr     = r_src;
        wr_en       = 1'b0;
        wr_addr     = r_src;
        wr_data     = r_rdata;

        // drop the result once taken
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_op     = s_axis_tuser;
                    n_key    = s_axis_tdata;
                    n_lo     = '0;
                    n_hx     = r_count;
                    n_hit    = 1'b0;
                    n_status = ST_DONE;
                    n_state  = S_PROBE;
                end
            end
            S_PROBE: begin
                if (r_lo < r_hx) begin
                    n_mid   = IDX_W'(mid_sum >> 1);
                    rd_en   = 1'b1;
                    rd_addr = IDX_W'(mid_sum >> 1);
                    n_state = S_CMP;
                end else begin
                    n_pos   = r_lo;
                    n_state = S_DECIDE;
                end
            end
            S_CMP: begin
                if (r_rdata == r_key) begin
                    n_hit   = 1'b1;
                    n_pos   = CNT_W'(r_mid);
                    n_state = S_DECIDE;
                end else begin
                    if (key_less) begin
                        n_hx = CNT_W'(r_mid);
                    end else begin
                        n_lo = CNT_W'(r_mid) + CNT_W'(1);
                    end
                    n_state = S_PROBE;
                end
            end
            S_DECIDE: begin
                n_state = S_FIN;
                case (r_op)
                    OP_INSERT: begin
                        if (r_hit) begin
                            n_status = ST_PRESENT;
                        end else if (r_count >= CNT_W'(CAPACITY)) begin
                            n_status = ST_FULL;
                        end else if (r_count == r_pos) begin
                            // append at the end
                            wr_en   = 1'b1;
                            wr_addr = IDX_W'(r_pos);
                            wr_data = r_key;
                            n_count = r_count + CNT_W'(1);
                        end else begin
                            n_src   = IDX_W'(r_count - CNT_W'(1));
                            n_state = S_UP_FIRST;
                        end
                    end
                    OP_DELETE: begin
                        if (!r_hit) begin
                            n_status = ST_ABSENT;
                        end else if (r_pos + CNT_W'(1) == r_count) begin
                            n_count = r_count - CNT_W'(1);
                        end else begin
                            // start pulling entries down
                            rd_en   = 1'b1;
                            rd_addr = IDX_W'(r_pos + CNT_W'(1));
                            n_src   = IDX_W'(r_pos + CNT_W'(1));
                            n_state = S_DN;
                        end
                    end
                    default: begin
                        n_status = ST_DONE;
                    end
                endcase
            end
            S_UP_FIRST: begin
                rd_en   = 1'b1;
                rd_addr = r_src;
                n_state = S_UP;
            end
            S_UP: begin
                // move entry up by one, then fetch the next lower one
                wr_en   = 1'b1;
                wr_addr = r_src + IDX_W'(1);
                wr_data = r_rdata;
                if (CNT_W'(r_src) == r_pos) begin
                    n_state = S_PUT;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_src - IDX_W'(1);
                    n_src   = r_src - IDX_W'(1);
                end
            end
            S_PUT: begin
                // write the new key into the opened gap
                wr_en   = 1'b1;
                wr_addr = IDX_W'(r_pos);
                wr_data = r_key;
                n_count = r_count + CNT_W'(1);
                n_state = S_FIN;
            end
            S_DN: begin
                // move entry down by one, then fetch the next higher one
                wr_en   = 1'b1;
                wr_addr = r_src - IDX_W'(1);
                wr_data = r_rdata;
                if (CNT_W'(r_src) + CNT_W'(1) == r_count) begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_FIN;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_src + IDX_W'(1);
                    n_src   = r_src + IDX_W'(1);
                end
            end
            S_FIN: begin
                // hand over once the output register is free
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = '0;
                    n_out_data[FOUND_LSB]                 = r_hit;
                    n_out_data[POS_LSB +: FLD_W]          = pos8;
                    n_out_data[BELOW_LSB +: FLD_W]        = below8;
                    n_out_data[ENTRIES_LSB +: FLD_W]      = FLD_W'(r_count);
                    n_out_data[STATUS_LSB +: STAT_W]      = r_status;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Table memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_key      <= n_key;
        r_lo       <= n_lo;
        r_hx       <= n_hx;
        r_mid      <= n_mid;
        r_src      <= n_src;
        r_pos      <= n_pos;
        r_hit      <= n_hit;
        r_status   <= n_status;
        r_out_data <= n_out_data;
    end

endmodule
`default_nettype wire

// ----- rtl/sst_checker.sv -----
// Port-level checks for the sorted key table, bound to the top level.
`default_nettype none
module sst_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       s_axis_tvalid,
    input wire logic                       s_axis_tready,
    input wire logic                       m_axis_tvalid,
    input wire logic                       m_axis_tready,
    input wire logic [sst_pkg::OUT_W-1:0]  m_axis_tdata
);
    import sst_pkg::*;

    logic                found;
    logic [FLD_W-1:0]    position;
    logic [FLD_W-1:0]    below_index;
    logic [FLD_W-1:0]    entries_after;
    logic [STAT_W-1:0]   status;

    assign found         = m_axis_tdata[FOUND_LSB];
    assign position      = m_axis_tdata[POS_LSB +: FLD_W];
    assign below_index   = m_axis_tdata[BELOW_LSB +: FLD_W];
    assign entries_after = m_axis_tdata[ENTRIES_LSB +: FLD_W];
    assign status        = m_axis_tdata[STATUS_LSB +: STAT_W];

    // Hold a result until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed or dropped while stalled");

    // Busy right after taking a word
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken again without a search in between");

    // A hit reports the same index on both sides
    a_hit_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && found |-> position == below_index)
        else $error("found key with mismatched indices");

    // Full refusal and skipped delete only on absent keys
    a_absent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (status == ST_FULL || status == ST_ABSENT) |-> !found)
        else $error("absent-key status with found set");

    // Full status only when the table holds CAPACITY entries
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && status == ST_FULL |-> entries_after == FLD_W'(CAPACITY))
        else $error("full status with table not full");

endmodule

bind sorted_set_table sst_checker u_sst_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
